### rtl/core/sphere_frustum_cull_top_assert.svh
// ----------------------------------------------------------------------------
// Sphere frustum cull assertion macros
// Short forms for the concurrent checks used in the culling block.
// ----------------------------------------------------------------------------
`ifndef SPHERE_FRUSTUM_CULL_TOP_ASSERT_SVH
`define SPHERE_FRUSTUM_CULL_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SFC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SFC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sfc_pkg.sv
// ----------------------------------------------------------------------------
// Sphere frustum cull package
// Widths, codes, FSM types and the control structs of the MAC pipeline.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int COEF_W = 32;     // Q16.16 operands
    localparam int FRAC_W = 16;
    localparam int PROD_W = 64;     // full Q32.32 product
    localparam int RND_W  = 48;     // product rounded to 16 fraction bits (Q32.16)
    localparam int ACC_W  = 50;     // three rounded products plus offset
    localparam int RAD_W  = 31;
    localparam int PIDX_W = 3;
    localparam int VIS_W  = 2;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sh0000_0000_0000_8000;
    localparam logic signed [ACC_W-1:0]  SAT_HI     = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0]  SAT_LO     = ACC_W'(-64'sd2147483648);
    localparam logic signed [COEF_W-1:0] S32_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] S32_MIN    = 32'sh8000_0000;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEST = 1'b1;

    localparam logic [VIS_W-1:0] VIS_OUTSIDE = 2'd0;
    localparam logic [VIS_W-1:0] VIS_PARTIAL = 2'd1;
    localparam logic [VIS_W-1:0] VIS_INSIDE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        STEP_A,
        STEP_B,
        STEP_C
    } step_t;

    typedef struct packed {
        logic valid;
        logic first;       // starts a new plane sum (loads offset)
        logic last;        // closes the plane sum
        logic last_plane;  // closes the final plane of the transaction
    } mac_op_t;

    typedef struct packed {
        logic valid;
        logic last_plane;
        logic outside;     // s < -r
        logic touch;       // s <= r
    } mac_res_t;

endpackage

### rtl/core/sfc_plane_file.sv
// ----------------------------------------------------------------------------
// Sphere frustum cull plane file
// Holds the (a, b, c, d) coefficients of every plane; one write, one read.
// ----------------------------------------------------------------------------
module sfc_plane_file import sfc_pkg::*; #(
    parameter int NUM_PLANES = 6,
    parameter int IDX_W      = 3
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_idx,
    input  logic signed [COEF_W-1:0] wr_a,
    input  logic signed [COEF_W-1:0] wr_b,
    input  logic signed [COEF_W-1:0] wr_c,
    input  logic signed [COEF_W-1:0] wr_d,
    input  logic [IDX_W-1:0]         rd_idx,
    output logic signed [COEF_W-1:0] rd_a,
    output logic signed [COEF_W-1:0] rd_b,
    output logic signed [COEF_W-1:0] rd_c,
    output logic signed [COEF_W-1:0] rd_d
);

    logic signed [COEF_W-1:0] a_reg [NUM_PLANES];
    logic signed [COEF_W-1:0] b_reg [NUM_PLANES];
    logic signed [COEF_W-1:0] c_reg [NUM_PLANES];
    logic signed [COEF_W-1:0] d_reg [NUM_PLANES];

    // planes read as zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                a_reg[i] <= '0;
                b_reg[i] <= '0;
                c_reg[i] <= '0;
                d_reg[i] <= '0;
            end
        end else if (wr_en) begin
            a_reg[wr_idx] <= wr_a;
            b_reg[wr_idx] <= wr_b;
            c_reg[wr_idx] <= wr_c;
            d_reg[wr_idx] <= wr_d;
        end
    end

    assign rd_a = a_reg[rd_idx];
    assign rd_b = b_reg[rd_idx];
    assign rd_c = c_reg[rd_idx];
    assign rd_d = d_reg[rd_idx];

endmodule

### rtl/core/sfc_mac.sv
// ----------------------------------------------------------------------------
// Sphere frustum cull multiply-accumulate unit
// Shared 32x32 multiplier, Q16.16 rounding, plane-sum accumulator and the
// saturate-and-compare stage against the sphere radius.
// ----------------------------------------------------------------------------
module sfc_mac import sfc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_op_t                  op,
    input  logic signed [COEF_W-1:0] op_coef,
    input  logic signed [COEF_W-1:0] op_center,
    input  logic signed [COEF_W-1:0] op_offset,
    input  logic [RAD_W-1:0]         radius,
    output mac_res_t                 res
);

    mac_op_t                  s1_reg, s2_reg;
    logic                     sum_valid_reg, sum_last_reg;
    mac_res_t                 res_reg, res_next;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [COEF_W-1:0] off1_reg, off2_reg;
    logic signed [RND_W-1:0]  rnd_reg, rnd_next;
    logic signed [PROD_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0]  acc_reg, acc_next, acc_base;

    logic signed [COEF_W-1:0] s_sat;
    logic signed [COEF_W:0]   s_ext, r_ext, neg_r;

    // stage 1: product, stage 2: round, stage 3: accumulate, stage 4: classify
    // signed 32x32 product, operands sign-extended to the full product width
    assign prod_next = PROD_W'(op_coef) * PROD_W'(op_center);
    assign rnd_sum   = prod_reg + ROUND_HALF;
    assign rnd_next  = rnd_sum[PROD_W-1:FRAC_W];
    assign acc_base  = s2_reg.first ? ACC_W'(off2_reg) : acc_reg;
    assign acc_next  = acc_base + ACC_W'(rnd_reg);

    always_comb begin
        if (acc_reg > SAT_HI) begin
            s_sat = S32_MAX;
        end else if (acc_reg < SAT_LO) begin
            s_sat = S32_MIN;
        end else begin
            s_sat = acc_reg[COEF_W-1:0];
        end
        s_ext = (COEF_W+1)'(s_sat);
        r_ext = $signed({2'b00, radius});
        neg_r = -r_ext;
        res_next.valid      = sum_valid_reg;
        res_next.last_plane = sum_last_reg;
        res_next.outside    = s_ext < neg_r;
        res_next.touch      = s_ext <= r_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            sum_valid_reg <= 1'b0;
            sum_last_reg  <= 1'b0;
            res_reg       <= '0;
        end else begin
            s1_reg        <= op;
            s2_reg        <= s1_reg;
            sum_valid_reg <= s2_reg.valid && s2_reg.last;
            sum_last_reg  <= s2_reg.last_plane;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        off1_reg <= op_offset;
        rnd_reg  <= rnd_next;
        off2_reg <= off1_reg;
        if (s2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/core/sphere_frustum_cull_top.sv
// ----------------------------------------------------------------------------
// Sphere frustum cull top level
// Classifies bounding spheres against a set of stored frustum planes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | kind, plane index, a b c d, x y z, radius
//  m_      | out       | m_valid / m_ready  | visibility (one per sphere test)
//
//  A plane load is written on acceptance. In a sphere test the single shared
//  32x32 multiplier does one product per cycle, three per plane, followed by
//  a four-stage drain and the output load.
//  Reset (aresetn low, synchronous) clears all planes to zero and the FSM.
//  s_ready is high only in idle; a held result stalls the next test at its
//  end, never at its start, so loads and a new test proceed under m_ready low.
// ----------------------------------------------------------------------------
`include "sphere_frustum_cull_top_assert.svh"

module sphere_frustum_cull_top import sfc_pkg::*; #(
    parameter int NUM_PLANES = 6
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input transactions
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic [PIDX_W-1:0]        s_plane_index,
    input  logic signed [COEF_W-1:0] s_coef_a,
    input  logic signed [COEF_W-1:0] s_coef_b,
    input  logic signed [COEF_W-1:0] s_coef_c,
    input  logic signed [COEF_W-1:0] s_coef_d,
    input  logic signed [COEF_W-1:0] s_center_x,
    input  logic signed [COEF_W-1:0] s_center_y,
    input  logic signed [COEF_W-1:0] s_center_z,
    input  logic [RAD_W-1:0]         s_radius,
    // result transactions
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [VIS_W-1:0]         m_visibility
);

    localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam logic [IDX_W-1:0] LAST_PLANE = IDX_W'(NUM_PLANES - 1);

    state_t                   state_reg, state_next;
    step_t                    step_reg, step_next;
    logic [IDX_W-1:0]         plane_reg, plane_next;
    logic                     outside_reg, outside_next;
    logic                     touch_reg, touch_next;
    logic                     m_valid_reg, m_valid_next;
    logic [VIS_W-1:0]         vis_reg, vis_next;

    logic signed [COEF_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [RAD_W-1:0]         radius_reg;

    logic                     in_fire, test_fire, load_fire, in_range;
    logic                     issue_end, out_load;

    logic signed [COEF_W-1:0] rd_a, rd_b, rd_c, rd_d;
    logic signed [COEF_W-1:0] op_coef, op_center;
    mac_op_t                  mac_op;
    mac_res_t                 mac_res;

    assign in_fire   = s_valid && s_ready;
    assign test_fire = in_fire && (s_kind == KIND_TEST);
    assign in_range  = int'(s_plane_index) < NUM_PLANES;
    // out-of-range loads are accepted and dropped
    assign load_fire = in_fire && (s_kind == KIND_LOAD) && in_range;
    assign issue_end = (step_reg == STEP_C) && (plane_reg == LAST_PLANE);

    sfc_plane_file #(
        .NUM_PLANES (NUM_PLANES),
        .IDX_W      (IDX_W)
    ) u_plane_file (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_fire),
        .wr_idx  (IDX_W'(s_plane_index)),
        .wr_a    (s_coef_a),
        .wr_b    (s_coef_b),
        .wr_c    (s_coef_c),
        .wr_d    (s_coef_d),
        .rd_idx  (plane_reg),
        .rd_a    (rd_a),
        .rd_b    (rd_b),
        .rd_c    (rd_c),
        .rd_d    (rd_d)
    );

    sfc_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (mac_op),
        .op_coef   (op_coef),
        .op_center (op_center),
        .op_offset (rd_d),
        .radius    (radius_reg),
        .res       (mac_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (test_fire) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (issue_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_res.valid && mac_res.last_plane) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs: handshake, MAC issue, operand select
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

        mac_op.valid      = (state_reg == ST_ISSUE);
        mac_op.first      = (step_reg == STEP_A);
        mac_op.last       = (step_reg == STEP_C);
        mac_op.last_plane = issue_end;

        case (step_reg)
            STEP_A: begin
                op_coef   = rd_a;
                op_center = cx_reg;
            end
            STEP_B: begin
                op_coef   = rd_b;
                op_center = cy_reg;
            end
            default: begin
                op_coef   = rd_c;
                op_center = cz_reg;
            end
        endcase
    end

    // sequencer counters, classification flags, output register
    always_comb begin
        step_next    = step_reg;
        plane_next   = plane_reg;
        outside_next = outside_reg;
        touch_next   = touch_reg;
        m_valid_next = m_valid_reg;
        vis_next     = vis_reg;

        if (test_fire) begin
            step_next    = STEP_A;
            plane_next   = '0;
            outside_next = 1'b0;
            touch_next   = 1'b0;
        end else if (state_reg == ST_ISSUE) begin
            case (step_reg)
                STEP_A:  step_next = STEP_B;
                STEP_B:  step_next = STEP_C;
                default: begin
                    step_next = STEP_A;
                    if (!issue_end) begin
                        plane_next = plane_reg + 1'b1;
                    end
                end
            endcase
        end

        // any plane with the sphere beyond it culls; any plane touching it
        // makes the sphere partial
        if (mac_res.valid) begin
            outside_next = outside_reg || mac_res.outside;
            touch_next   = touch_reg || mac_res.touch;
        end

        if (out_load) begin
            m_valid_next = 1'b1;
            if (outside_reg) begin
                vis_next = VIS_OUTSIDE;
            end else if (touch_reg) begin
                vis_next = VIS_PARTIAL;
            end else begin
                vis_next = VIS_INSIDE;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_A;
            plane_reg   <= '0;
            outside_reg <= 1'b0;
            touch_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            plane_reg   <= plane_next;
            outside_reg <= outside_next;
            touch_reg   <= touch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // sphere operands held for the whole test transaction
    always_ff @(posedge aclk) begin
        vis_reg <= vis_next;
        if (test_fire) begin
            cx_reg     <= s_center_x;
            cy_reg     <= s_center_y;
            cz_reg     <= s_center_z;
            radius_reg <= s_radius;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_visibility = vis_reg;

    `SFC_ASSERT_IMP(a_idle_pipe_empty, aclk, aresetn, s_ready, !mac_res.valid, "MAC result while idle")
    `SFC_ASSERT_IMP(a_last_in_drain, aclk, aresetn, mac_res.valid && mac_res.last_plane, state_reg == ST_DRAIN, "final plane result outside drain")
    `SFC_ASSERT_NXT(a_issue_to_drain, aclk, aresetn, state_reg == ST_ISSUE && issue_end, state_reg == ST_DRAIN, "issue did not end after last plane")
    `SFC_ASSERT_NXT(a_flags_cleared, aclk, aresetn, test_fire, !outside_reg && !touch_reg, "flags not cleared on new test")

endmodule

### verif/tb_sphere_frustum_cull_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere frustum cull testbench
// Loads frustum planes and streams sphere tests through the culling block
// under random source gaps and sink stalls. Each visibility result is checked
// against a plane-by-plane Q16.16 prediction kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_sphere_frustum_cull_top;
    import sfc_pkg::*;

    localparam int NUM_PLANES   = 6;
    localparam int RANDOM_ITEMS = 1125;       // plus the directed part, ~1150
    localparam int CYCLE_LIMIT  = 1_000_000;  // watchdog, well above worst case
    localparam int DRAIN_LIMIT  = 20_000;     // max wait for outstanding results
    localparam int TAIL_CYCLES  = 64;         // longer than one sphere test

    localparam logic signed [COEF_W-1:0] Q_ONE    = 32'sh0001_0000;
    localparam logic [RAD_W-1:0]         RAD_MAX  = 31'h7FFF_FFFF;
    localparam logic [RAD_W-1:0]         RAD_ONE  = 31'h0001_0000;

    // value ranges used for random frustums and spheres
    typedef enum int {
        MODE_TYPICAL,   // unit-ish normals, offsets and centers around 2^6
        MODE_GRID,      // coarse exact values, so s == r and s == -r show up
        MODE_FINE,      // small raw values that exercise product rounding
        MODE_WIDE       // full 32-bit range, mostly saturating sums
    } value_mode_t;

    // one input transaction, field by field
    typedef struct {
        logic                     kind;
        logic [PIDX_W-1:0]        plane_index;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
        logic signed [COEF_W-1:0] coef_d;
        logic signed [COEF_W-1:0] center_x;
        logic signed [COEF_W-1:0] center_y;
        logic signed [COEF_W-1:0] center_z;
        logic [RAD_W-1:0]         radius;
    } cull_item_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the plane stores, the visibility predictor
    // and the queue of visibilities still owed by the block.
    // ------------------------------------------------------------------------
    class frustum_scoreboard;
        logic signed [COEF_W-1:0] plane_a [NUM_PLANES];
        logic signed [COEF_W-1:0] plane_b [NUM_PLANES];
        logic signed [COEF_W-1:0] plane_c [NUM_PLANES];
        logic signed [COEF_W-1:0] plane_d [NUM_PLANES];
        logic [VIS_W-1:0]         owed_vis [$];
        int                       mismatches;

        function new();
            for (int i = 0; i < NUM_PLANES; i++) begin
                plane_a[i] = '0;
                plane_b[i] = '0;
                plane_c[i] = '0;
                plane_d[i] = '0;
            end
            mismatches = 0;
        endfunction

        task report(input string what);
            mismatches++;
            $display("[%0t] %s", $time, what);
        endtask

        // Q16.16 x Q16.16, round half up, floor to 16 fraction bits (Q32.16)
        function longint q16_product(logic signed [COEF_W-1:0] p,
                                     logic signed [COEF_W-1:0] q);
            longint full;
            full = longint'(p) * longint'(q) + 64'sd32768;
            return full >>> FRAC_W;
        endfunction

        function logic [VIS_W-1:0] classify_sphere(cull_item_t it);
            longint s;
            longint rad;
            bit     touch;
            rad   = longint'(it.radius);
            touch = 1'b0;
            for (int i = 0; i < NUM_PLANES; i++) begin
                s = q16_product(plane_a[i], it.center_x)
                  + q16_product(plane_b[i], it.center_y)
                  + q16_product(plane_c[i], it.center_z)
                  + longint'(plane_d[i]);
                if (s > longint'(S32_MAX))
                    s = longint'(S32_MAX);
                if (s < longint'(S32_MIN))
                    s = longint'(S32_MIN);
                if (s < -rad)
                    return VIS_OUTSIDE;
                if (s <= rad)
                    touch = 1'b1;
            end
            return touch ? VIS_PARTIAL : VIS_INSIDE;
        endfunction

        // called once per accepted input transaction
        function void accept_input(cull_item_t it);
            if (it.kind == KIND_TEST) begin
                owed_vis.push_back(classify_sphere(it));
            end else if (it.plane_index < NUM_PLANES) begin
                plane_a[it.plane_index] = it.coef_a;
                plane_b[it.plane_index] = it.coef_b;
                plane_c[it.plane_index] = it.coef_c;
                plane_d[it.plane_index] = it.coef_d;
            end
        endfunction

        // called once per accepted result transaction
        task check_visibility(input logic [VIS_W-1:0] got);
            logic [VIS_W-1:0] want;
            if (owed_vis.size() == 0) begin
                report($sformatf("visibility %0d arrived with nothing owed", got));
            end else begin
                want = owed_vis.pop_front();
                if (got !== want)
                    report($sformatf("visibility mismatch: got %0d, expected %0d",
                                     got, want));
            end
        endtask

        function int pending();
            return owed_vis.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_kind;
    logic [PIDX_W-1:0]        s_plane_index;
    logic signed [COEF_W-1:0] s_coef_a;
    logic signed [COEF_W-1:0] s_coef_b;
    logic signed [COEF_W-1:0] s_coef_c;
    logic signed [COEF_W-1:0] s_coef_d;
    logic signed [COEF_W-1:0] s_center_x;
    logic signed [COEF_W-1:0] s_center_y;
    logic signed [COEF_W-1:0] s_center_z;
    logic [RAD_W-1:0]         s_radius;
    logic                     m_valid;
    logic                     m_ready;
    logic [VIS_W-1:0]         m_visibility;

    frustum_scoreboard sb;
    int                counted_items;  // loads that store a plane, and tests
    bit                sender_burst;   // no source gaps during this stretch
    int                cycle_count;

    sphere_frustum_cull_top #(
        .NUM_PLANES (NUM_PLANES)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_plane_index (s_plane_index),
        .s_coef_a      (s_coef_a),
        .s_coef_b      (s_coef_b),
        .s_coef_c      (s_coef_c),
        .s_coef_d      (s_coef_d),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_center_z    (s_center_z),
        .s_radius      (s_radius),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_visibility  (m_visibility)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog. Worst case is ~1200 tests, each busy for a whole test plus the
    // longest source gap and sink stall; the limit is several times that.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_sphere_frustum_cull_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: m_ready toggles at the falling edge, mostly short stalls,
    // a few long ones, and now and then a long run with no stall at all.
    // Results are sampled at the rising edge.
    // ------------------------------------------------------------------------
    initial begin
        int run_len;
        int stall_len;
        m_ready = 1'b0;
        forever begin
            if ($urandom_range(0, 3) == 0)
                run_len = $urandom_range(50, 200);
            else
                run_len = $urandom_range(1, 8);
            if ($urandom_range(0, 99) < 85)
                stall_len = $urandom_range(1, 3);
            else
                stall_len = $urandom_range(10, 40);
            @(negedge aclk);
            m_ready = 1'b1;
            repeat (run_len - 1) @(negedge aclk);
            @(negedge aclk);
            m_ready = 1'b0;
            repeat (stall_len - 1) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_visibility(m_visibility);
    end

    // ------------------------------------------------------------------------
    // Source side helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_burst || roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic int srand(int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_value(value_mode_t mode,
                                                            bit is_normal);
        case (mode)
            MODE_TYPICAL: return is_normal ? srand(32'h1_0000) : srand(32'h40_0000);
            MODE_GRID:    return is_normal ? srand(4) * 32'sh4000 : srand(8) * 32'sh8000;
            MODE_FINE:    return srand(32'h4_0000);
            default:      return $urandom;
        endcase
    endfunction

    function automatic logic [RAD_W-1:0] pick_radius(value_mode_t mode);
        case (mode)
            MODE_TYPICAL: return RAD_W'($urandom_range(0, 32'h20_0000));
            MODE_GRID:    return RAD_W'($urandom_range(0, 8) * 32'h8000);
            MODE_FINE:    return RAD_W'($urandom_range(0, 32'h4_0000));
            default:      return RAD_W'($urandom);
        endcase
    endfunction

    // all fields random; ignored fields keep this junk
    function automatic cull_item_t random_item();
        cull_item_t it;
        it.kind        = 1'($urandom_range(0, 1));
        it.plane_index = PIDX_W'($urandom_range(0, 7));
        it.coef_a      = $urandom;
        it.coef_b      = $urandom;
        it.coef_c      = $urandom;
        it.coef_d      = $urandom;
        it.center_x    = $urandom;
        it.center_y    = $urandom;
        it.center_z    = $urandom;
        it.radius      = RAD_W'($urandom);
        return it;
    endfunction

    // Present one transaction from a falling edge, hold it until accepted,
    // then idle for a random gap. Returns at a falling edge. With no gap,
    // s_valid simply stays high into the next transaction.
    task automatic drive_item(input cull_item_t it);
        int gap;
        s_kind        = it.kind;
        s_plane_index = it.plane_index;
        s_coef_a      = it.coef_a;
        s_coef_b      = it.coef_b;
        s_coef_c      = it.coef_c;
        s_coef_d      = it.coef_d;
        s_center_x    = it.center_x;
        s_center_y    = it.center_y;
        s_center_z    = it.center_z;
        s_radius      = it.radius;
        s_valid       = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.accept_input(it);
        if (it.kind == KIND_TEST || it.plane_index < NUM_PLANES)
            counted_items++;
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_load(input logic [PIDX_W-1:0] idx,
                             input logic signed [COEF_W-1:0] a, b, c, d);
        cull_item_t it;
        it             = random_item();
        it.kind        = KIND_LOAD;
        it.plane_index = idx;
        it.coef_a      = a;
        it.coef_b      = b;
        it.coef_c      = c;
        it.coef_d      = d;
        drive_item(it);
    endtask

    task automatic send_test(input logic signed [COEF_W-1:0] x, y, z,
                             input logic [RAD_W-1:0] r);
        cull_item_t it;
        it          = random_item();
        it.kind     = KIND_TEST;
        it.center_x = x;
        it.center_y = y;
        it.center_z = z;
        it.radius   = r;
        drive_item(it);
    endtask

    // hold the source off until every owed visibility has come back
    task automatic wait_results_drained();
        int waited;
        waited  = 0;
        s_valid = 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        value_mode_t mode;
        int          choice;
        int          n_tests;
        int          roll;

        sb            = new();
        counted_items = 0;
        sender_burst  = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = KIND_LOAD;
        s_plane_index = '0;
        s_coef_a      = '0;
        s_coef_b      = '0;
        s_coef_c      = '0;
        s_coef_d      = '0;
        s_center_x    = '0;
        s_center_y    = '0;
        s_center_z    = '0;
        s_radius      = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // --- directed part -------------------------------------------------
        // planes are all zero after reset: s = 0 <= r, so partly inside
        send_test('0, '0, '0, '0);
        send_test(S32_MAX, S32_MIN, S32_MAX, RAD_MAX);
        // plane indices past the last plane must not store anything
        send_load(3'd6, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
        send_load(3'd7, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
        send_test($urandom, $urandom, $urandom, '0);
        // every plane at offset +1.0: inside for r < 1.0, partial at r == s
        for (int p = 0; p < NUM_PLANES; p++)
            send_load(3'(p), '0, '0, '0, Q_ONE);
        send_test($urandom, $urandom, $urandom, '0);
        send_test($urandom, $urandom, $urandom, RAD_ONE);
        send_test($urandom, $urandom, $urandom, RAD_ONE - 1'b1);
        // one plane at -1.0: s == -r is still partial, below -r is outside
        send_load(3'd3, '0, '0, '0, -Q_ONE);
        send_test($urandom, $urandom, $urandom, RAD_ONE);
        send_test($urandom, $urandom, $urandom, RAD_ONE - 1'b1);
        // sum saturating low: -2^31 < -(2^31-1) even at the largest radius
        send_load(3'd3, S32_MIN, '0, '0, '0);
        send_test(S32_MAX, '0, '0, RAD_MAX);
        // sum saturating high, then rounding ties on plane 0
        send_load(3'd3, S32_MAX, S32_MIN, S32_MAX, S32_MAX);
        send_test(S32_MAX, S32_MIN, S32_MAX, RAD_MAX);
        send_load(3'd0, 32'sd1, -32'sd1, '0, '0);
        send_test(32'sh8000, 32'sh8000, '0, '0);
        send_test(32'sh8000, 32'sh8000, '0, 31'd1);
        wait_results_drained();

        // --- random part ---------------------------------------------------
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            choice       = $urandom_range(0, 99);
            roll         = $urandom_range(0, 99);
            sender_burst = ($urandom_range(0, 4) == 0);
            if (roll < 40)
                mode = MODE_TYPICAL;
            else if (roll < 70)
                mode = MODE_GRID;
            else if (roll < 90)
                mode = MODE_FINE;
            else
                mode = MODE_WIDE;

            if (choice < 65) begin
                // full frustum reload followed by a batch of spheres
                for (int p = 0; p < NUM_PLANES; p++)
                    send_load(3'(p), pick_value(mode, 1'b1), pick_value(mode, 1'b1),
                              pick_value(mode, 1'b1), pick_value(mode, 1'b0));
                n_tests = $urandom_range(3, 12);
                repeat (n_tests)
                    send_test(pick_value(mode, 1'b0), pick_value(mode, 1'b0),
                              pick_value(mode, 1'b0), pick_radius(mode));
            end else if (choice < 85) begin
                // single plane update
                send_load(PIDX_W'($urandom_range(0, NUM_PLANES - 1)),
                          pick_value(mode, 1'b1), pick_value(mode, 1'b1),
                          pick_value(mode, 1'b1), pick_value(mode, 1'b0));
                n_tests = $urandom_range(1, 4);
                repeat (n_tests)
                    send_test(pick_value(mode, 1'b0), pick_value(mode, 1'b0),
                              pick_value(mode, 1'b0), pick_radius(mode));
            end else if (choice < 97) begin
                // noise: any kind, any index including the unused ones
                n_tests = $urandom_range(1, 4);
                repeat (n_tests)
                    drive_item(random_item());
            end else begin
                wait_results_drained();
            end
        end

        // --- wind down -----------------------------------------------------
        wait_results_drained();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d visibility results never arrived", sb.pending()));
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (sb.mismatches == 0)
            $display("tb_sphere_frustum_cull_top: clean");
        else
            $display("tb_sphere_frustum_cull_top: errors");
        $finish;
    end

endmodule

### sphere_frustum_cull_top.f
+incdir+rtl/core
rtl/core/sfc_pkg.sv
rtl/core/sfc_plane_file.sv
rtl/core/sfc_mac.sv
rtl/core/sphere_frustum_cull_top.sv
verif/tb_sphere_frustum_cull_top.sv
